@@ hdl/vpra_pkg.sv @@
// Shared types and codes for the virtual-to-physical register allocator.
// No dependencies; imported by every other file of the block but vpra_ram.
package vpra_pkg;

   // request and response payloads
   typedef struct packed {
      logic        cmd;
      logic [12:0] virt_reg;
   } req_type;

   typedef struct packed {
      logic [2:0] phys_reg;
      logic [2:0] status;
   } rsp_type;

   // request commands
   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // response status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EXHAUSTED = 3'd1;
   localparam logic [2:0] ST_UNMAPPED  = 3'd2;
   localparam logic [2:0] ST_STALE     = 3'd3;
   localparam logic [2:0] ST_IGNORED   = 3'd4;

   // register map: index held in paddr[2]
   localparam logic CSR_IDX_PHYS_REG_COUNT = 1'b0;
   localparam logic [3:0] PHYS_REG_COUNT_RST = 4'd8;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic clear;
      logic execute;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_done;
   } ctl_sts_type;

endpackage

@@ hdl/vpra_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vpra_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/vpra_ctrl.sv @@
// Sequencer for the allocator: clearing pass, idle, execute.
// Depends on vpra_pkg.
module vpra_ctrl import vpra_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  ctl_sts_type sts,
   output logic        busy,
   output ctl_cmd_type ctl
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sts.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      busy_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy        = busy_ff;
   assign ctl.capture = (state_ff == S_IDLE) && start;
   assign ctl.clear   = (state_ff == S_CLEAR);
   assign ctl.execute = (state_ff == S_EXEC);

endmodule

@@ hdl/vpra_dp.sv @@
// Allocator datapath: map table RAM, busy bits, free search, response register.
// Depends on vpra_pkg and vpra_ram.
module vpra_dp import vpra_pkg::*; #(
   parameter int VIRT_REGS = 8192,
   parameter int PHYS_REGS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_cmd_type ctl,
   output ctl_sts_type sts,
   input  req_type     req_data,
   input  logic [3:0]  reg_count,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   localparam int AW = $clog2(VIRT_REGS);
   localparam int PW = (PHYS_REGS > 1) ? $clog2(PHYS_REGS) : 1;
   localparam int LW = $clog2(PHYS_REGS + 1);
   localparam int EW = PW + 1;

   req_type               req_ff, req_in;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   logic [PHYS_REGS-1:0]  busy_bits_ff, busy_bits_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [31:0]   new_ext, cur_ext, phys_ext;
   logic [AW-1:0] cur_addr;
   logic          in_range;
   logic [EW-1:0] rd_data, wr_data;
   logic [AW-1:0] wr_addr;
   logic          wr_en;
   logic          map_valid;
   logic [PW-1:0] map_phys;
   logic          phys_ok, mapped_busy;
   logic [LW-1:0] limit;
   logic          free_found;
   logic [PW-1:0] free_idx;
   logic          alloc_wr, rel_clr;

   assign new_ext  = 32'(req_data.virt_reg);
   assign cur_ext  = 32'(req_ff.virt_reg);
   assign cur_addr = cur_ext[AW-1:0];
   assign in_range = cur_ext < 32'(VIRT_REGS);

   // map table entry: valid bit over physical index
   assign wr_en   = ctl.clear || (ctl.execute && alloc_wr);
   assign wr_addr = ctl.clear ? clr_addr_ff : cur_addr;
   assign wr_data = ctl.clear ? '0 : {1'b1, free_idx};

   vpra_ram #(
      .WIDTH (EW),
      .DEPTH (VIRT_REGS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl.capture),
      .rd_addr (new_ext[AW-1:0]),
      .rd_data (rd_data)
   );

   assign map_valid   = rd_data[EW-1];
   assign map_phys    = rd_data[PW-1:0];
   assign phys_ok     = 32'(map_phys) < 32'(PHYS_REGS);
   assign mapped_busy = map_valid && phys_ok && busy_bits_ff[map_phys];

   // effective count is capped at the number of physical registers
   assign limit = (32'(reg_count) > 32'(PHYS_REGS)) ? LW'(PHYS_REGS) : LW'(reg_count);

   // lowest free register below the limit
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = PHYS_REGS - 1; i >= 0; i--) begin
         if ((LW'(i) < limit) && !busy_bits_ff[i]) begin
            free_found = 1'b1;
            free_idx   = PW'(i);
         end
      end
   end

   always_comb begin
      alloc_wr        = 1'b0;
      rel_clr         = 1'b0;
      phys_ext        = '0;
      rsp_in.status   = ST_OK;
      if (req_ff.virt_reg == '0) begin
         rsp_in.status = ST_IGNORED;
      end else if (req_ff.cmd == CMD_ALLOC) begin
         if (!in_range) begin
            rsp_in.status = ST_EXHAUSTED;
         end else if (map_valid) begin
            if (mapped_busy) begin
               phys_ext = 32'(map_phys);
            end else begin
               rsp_in.status = ST_STALE;
            end
         end else if (free_found) begin
            alloc_wr = 1'b1;
            phys_ext = 32'(free_idx);
         end else begin
            rsp_in.status = ST_EXHAUSTED;
         end
      end else begin
         if (in_range && mapped_busy) begin
            rel_clr  = 1'b1;
            phys_ext = 32'(map_phys);
         end else begin
            rsp_in.status = ST_UNMAPPED;
         end
      end
      rsp_in.phys_reg = phys_ext[2:0];
   end

   always_comb begin
      req_in       = ctl.capture ? req_data : req_ff;
      clr_addr_in  = ctl.clear ? clr_addr_ff + AW'(1) : clr_addr_ff;
      rsp_valid_in = ctl.execute;
      busy_bits_in = busy_bits_ff;
      if (ctl.execute && alloc_wr) busy_bits_in[free_idx] = 1'b1;
      if (ctl.execute && rel_clr)  busy_bits_in[map_phys] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         busy_bits_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         busy_bits_ff <= busy_bits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (ctl.execute) rsp_ff <= rsp_in;
   end

   assign sts.clr_done = (clr_addr_ff == AW'(VIRT_REGS - 1));
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule

@@ hdl/virtual_to_physical_register_allocator.sv @@
// Top level of the virtual-to-physical register allocator: register port,
// controller and datapath. Depends on vpra_pkg, vpra_ctrl, vpra_dp, vpra_ram.
//
//   channel   | ports                                   | handshake
//   ----------+-----------------------------------------+---------------------------
//   request   | start, busy, req_data                   | taken when start && !busy
//   response  | rsp_valid, rsp_data                     | one-cycle strobe, no stall
//   register  | psel, penable, pwrite, paddr, pwdata,   | write on access phase,
//             | prdata, pready                          | pready tied high
//
// Sequence: the entry is read at the accepting edge, checked and written back
//   with the busy bits in the next cycle (busy high), and the response strobes in
//   the cycle after, with busy low so a request can follow.
// Reset: synchronous; afterwards a clearing pass writes every map table
//   entry invalid, with busy held high.
// Stalls: the receiver cannot hold off responses; phys_reg_count may only be
//   written while idle.
module virtual_to_physical_register_allocator import vpra_pkg::*; #(
   parameter int VIRT_REGS = 8192,
   parameter int PHYS_REGS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   // response
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   ctl_cmd_type ctl;
   ctl_sts_type sts;

   // phys_reg_count register; word index in paddr[2]
   logic [3:0] count_ff, count_in;
   logic       csr_wr;
   logic       csr_hit;

   assign csr_hit  = (paddr[2] == CSR_IDX_PHYS_REG_COUNT);
   assign csr_wr   = psel && penable && pwrite && csr_hit;
   assign count_in = csr_wr ? pwdata[3:0] : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= PHYS_REG_COUNT_RST;
      end else begin
         count_ff <= count_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = csr_hit ? {28'd0, count_ff} : 32'd0;

   // sequencing: clear pass, then idle / execute per request
   vpra_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .ctl   (ctl)
   );

   // map table, busy bits, lowest-free search and response register
   vpra_dp #(
      .VIRT_REGS (VIRT_REGS),
      .PHYS_REGS (PHYS_REGS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (sts),
      .req_data  (req_data),
      .reg_count (count_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hdl/vpra_checker.sv @@
// Port-level checks for the allocator, bound to the top level.
// Depends on vpra_pkg and virtual_to_physical_register_allocator.
module vpra_checker import vpra_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // every accepted request gets its response, strobed after the execute state
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("response missing after request");

   // busy rises straight after a request is taken
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after request");

   // responses never come in adjacent cycles
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back responses");

   // failed status carries no physical register
   a_phys_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.phys_reg == 3'd0))
      else $error("non-zero phys_reg on failure");

   // status code within the defined set
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_OK || rsp_data.status == ST_EXHAUSTED ||
                     rsp_data.status == ST_UNMAPPED || rsp_data.status == ST_STALE ||
                     rsp_data.status == ST_IGNORED))
      else $error("undefined status code");

endmodule

bind virtual_to_physical_register_allocator vpra_checker u_vpra_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
